FILE: rtl/uleb_pkg.sv
// ----------------------------------------------------------------------------
// uleb_pkg
// Beat types, status codes and the UTF-8 encoder shared by the line buffer.
// ----------------------------------------------------------------------------
package uleb_pkg;

    typedef struct packed {
        logic        req_type;
        logic [20:0] code_point;
        logic [7:0]  read_index;
    } in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] text_length;
        logic [7:0] read_byte;
    } out_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
    } enc_t;

    localparam logic REQ_KEY  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [2:0] ST_APPENDED = 3'd0;
    localparam logic [2:0] ST_DELETED  = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_NOROOM   = 3'd3;
    localparam logic [2:0] ST_IGNORED  = 3'd4;
    localparam logic [2:0] ST_READ     = 3'd5;

    localparam logic [20:0] CP_BACKSPACE = 21'd8;
    localparam logic [20:0] CP_DELETE    = 21'h7F;
    localparam logic [20:0] CP_PRINTABLE = 21'd32;

    localparam logic [8:0] CAPACITY_RESET = 9'd256;

    // Lead byte in bytes[0]; continuation bytes follow.
    function automatic enc_t encode_cp(input logic [20:0] cp);
        enc_t e;
        e.bytes = '0;
        if (cp < 21'h80) begin
            e.bytes[0] = cp[7:0];
            e.count    = 3'd1;
        end else if (cp < 21'h800) begin
            e.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
            e.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
            e.count    = 3'd2;
        end else if (cp < 21'h10000) begin
            e.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
            e.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
            e.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
            e.count    = 3'd3;
        end else begin
            e.bytes[0] = 8'hF0 | {5'b00000, cp[20:18]};
            e.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
            e.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
            e.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
            e.count    = 3'd4;
        end
        return e;
    endfunction

endpackage

FILE: rtl/utf8_line_edit_buffer_top.sv
// Each reply waits in S_DONE for the output register; output stalls hold it
// there. A read below the length first takes the registered RAM read (S_RDW),
// an append writes its encoded bytes in S_WR, and a delete steps back in S_DELRD
// over continuation bytes to the lead byte. One item at a time, one byte a cycle.
// Reset: synchronous, active low; empties the text and sets capacity to 256.
// The byte store is not cleared; only entries below the length are ever read.
// ----------------------------------------------------------------------------
// utf8_line_edit_buffer_top
// One-line UTF-8 text buffer: appends encoded printable code points, deletes the last
// character, and returns stored bytes on request.
// ----------------------------------------------------------------------------
module utf8_line_edit_buffer_top #(
    parameter int BUF_BYTES = 256
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [8:0]       cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  uleb_pkg::in_t    s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output uleb_pkg::out_t   m_data
);

    localparam int ADDR_W = $clog2(BUF_BYTES);
    localparam int IDX_W  = (ADDR_W > 8) ? ADDR_W : 8;
    localparam int SUM_W  = ((ADDR_W > 9) ? ADDR_W : 9) + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RDW   = 3'd1;
    localparam logic [2:0] S_DELRD = 3'd2;
    localparam logic [2:0] S_WR    = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [ADDR_W-1:0]    len_reg, len_next;
    logic [ADDR_W-1:0]    pos_reg, pos_next;
    logic [8:0]           cap_reg, cap_next;
    logic [1:0]           cnt_reg, cnt_next;
    uleb_pkg::enc_t       enc_reg, enc_next;
    logic [2:0]           res_status_reg, res_status_next;
    logic [7:0]           res_byte_reg, res_byte_next;
    logic                 m_valid_reg, m_valid_next;
    uleb_pkg::out_t       m_data_reg, m_data_next;

    uleb_pkg::enc_t       enc_in;
    logic [IDX_W-1:0]     idx_ext;
    logic [SUM_W-1:0]     sum_len;
    logic [SUM_W-1:0]     cap_eff;
    logic                 is_del;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [7:0]           mem_wdata;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [7:0]           mem_rdata;

    uleb_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_text_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign enc_in  = uleb_pkg::encode_cp(s_data.code_point);
    assign idx_ext = IDX_W'(s_data.read_index);
    assign sum_len = SUM_W'(len_reg) + SUM_W'(enc_in.count);
    assign cap_eff = (SUM_W'(cap_reg) > SUM_W'(BUF_BYTES)) ? SUM_W'(BUF_BYTES)
                                                            : SUM_W'(cap_reg);
    assign is_del  = (s_data.code_point == uleb_pkg::CP_BACKSPACE) ||
                     (s_data.code_point == uleb_pkg::CP_DELETE);

    assign mem_we    = (state_reg == S_WR);
    assign mem_waddr = len_reg + ADDR_W'(cnt_reg);
    assign mem_wdata = enc_reg.bytes[cnt_reg];

    always_comb begin
        if (state_reg == S_DELRD) begin
            mem_raddr = pos_reg - ADDR_W'(1);
        end else if (s_data.req_type == uleb_pkg::REQ_READ) begin
            mem_raddr = idx_ext[ADDR_W-1:0];
        end else begin
            mem_raddr = len_reg - ADDR_W'(1);
        end
    end

    always_comb begin
        state_next      = state_reg;
        len_next        = len_reg;
        pos_next        = pos_reg;
        cap_next        = cap_reg;
        cnt_next        = cnt_reg;
        enc_next        = enc_reg;
        res_status_next = res_status_reg;
        res_byte_next   = res_byte_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        if (cfg_valid) begin
            cap_next = cfg_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_byte_next = 8'h00;
                    if (s_data.req_type == uleb_pkg::REQ_READ) begin
                        res_status_next = uleb_pkg::ST_READ;
                        if (idx_ext < IDX_W'(len_reg)) begin
                            state_next = S_RDW;
                        end else begin
                            state_next = S_DONE;
                        end
                    end else if (is_del) begin
                        if (len_reg == '0) begin
                            res_status_next = uleb_pkg::ST_EMPTY;
                            state_next      = S_DONE;
                        end else begin
                            res_status_next = uleb_pkg::ST_DELETED;
                            pos_next        = len_reg - ADDR_W'(1);
                            if (len_reg == ADDR_W'(1)) begin
                                len_next   = '0;
                                state_next = S_DONE;
                            end else begin
                                state_next = S_DELRD;
                            end
                        end
                    end else if (s_data.code_point >= uleb_pkg::CP_PRINTABLE) begin
                        if (sum_len < cap_eff) begin
                            res_status_next = uleb_pkg::ST_APPENDED;
                            enc_next        = enc_in;
                            cnt_next        = 2'd0;
                            state_next      = S_WR;
                        end else begin
                            res_status_next = uleb_pkg::ST_NOROOM;
                            state_next      = S_DONE;
                        end
                    end else begin
                        res_status_next = uleb_pkg::ST_IGNORED;
                        state_next      = S_DONE;
                    end
                end
            end
            S_RDW: begin
                res_byte_next = mem_rdata;
                state_next    = S_DONE;
            end
            S_DELRD: begin
                // step back over continuation bytes, stop at the lead byte
                if (mem_rdata[7:6] == 2'b10) begin
                    pos_next = pos_reg - ADDR_W'(1);
                    if (pos_reg == ADDR_W'(1)) begin
                        len_next   = '0;
                        state_next = S_DONE;
                    end
                end else begin
                    len_next   = pos_reg;
                    state_next = S_DONE;
                end
            end
            S_WR: begin
                cnt_next = cnt_reg + 2'd1;
                if ({1'b0, cnt_reg} == enc_reg.count - 3'd1) begin
                    len_next   = len_reg + ADDR_W'(enc_reg.count);
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.status      = res_status_reg;
                    m_data_next.text_length = 8'(len_reg);
                    m_data_next.read_byte   = res_byte_reg;
                    state_next              = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            cap_reg     <= uleb_pkg::CAPACITY_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            cap_reg     <= cap_next;
            m_valid_reg <= m_valid_next;
        end
        pos_reg        <= pos_next;
        cnt_reg        <= cnt_next;
        enc_reg        <= enc_next;
        res_status_reg <= res_status_next;
        res_byte_reg   <= res_byte_next;
        m_data_reg     <= m_data_next;
    end

endmodule

FILE: rtl/uleb_ram.sv
// ----------------------------------------------------------------------------
// uleb_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module uleb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
